>>> hw/rtl/cfkm_pkg.sv
package cfkm_pkg;

    localparam int PHRASE_COUNT     = 11;
    localparam int PHRASE_MAX_BYTES = 43;
    localparam int PHRASE_BITS      = PHRASE_MAX_BYTES * 8;
    localparam int PHRASE_INDEX_W   = 4;

    typedef logic [PHRASE_MAX_BYTES-1:0] progress_t;
    typedef logic [PHRASE_COUNT-1:0]     seen_t;

    // Folded bytes presented to the matcher bank together.
    typedef struct packed {
        logic       en_first;
        logic       en_second;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       clear;
    } feed_t;

    localparam logic [7:0] ASCII_UPPER_LO = 8'h41;
    localparam logic [7:0] ASCII_UPPER_HI = 8'h5A;
    localparam logic [7:0] LEAD_D0        = 8'hD0;
    localparam logic [7:0] LEAD_D1        = 8'hD1;
    localparam logic [7:0] CYR_CAP_LO     = 8'h90;
    localparam logic [7:0] CYR_CAP_MID    = 8'h9F;
    localparam logic [7:0] CYR_CAP_HI     = 8'hAF;
    localparam logic [7:0] CASE_DELTA     = 8'h20;
    localparam logic [7:0] CYR_IO_CAP     = 8'h81;
    localparam logic [7:0] CYR_IO_SMALL   = 8'h91;

    localparam int PHRASE_LEN [PHRASE_COUNT] = '{
        38, 29, 21, 29, 26, 22, 16, 31, 22, 19, 43
    };

    // First phrase byte sits in the top byte of each entry, zero padded below.
    localparam logic [PHRASE_BITS-1:0] PHRASE_TEXT [PHRASE_COUNT] = '{
        {304'hd0b7d0b0d180d0b0d0b1d0bed182d0b0d0b920d0b220d182d0b5d0bbd0b5d0b3d180d0b0d0bc,
         40'h0},
        {232'hd0bfd0b0d181d181d0b8d0b2d0bdd18bd0b920d0b4d0bed185d0bed0b4, 112'h0},
        {168'hd0b2d0bbd0bed0b6d0b5d0bdd0b8d0b520d0bed182, 176'h0},
        {232'hd0b3d0b0d180d0b0d0bdd182d0b8d18f20d0b4d0bed185d0bed0b4d0b0, 112'h0},
        {208'hd0bdd183d0b6d0bdd18b20d0bbd18ed0b4d0b820d0b4d0bbd18f, 136'h0},
        {176'hd181d181d18bd0bbd0bad0b020d0b220d0b1d0b8d0be, 168'h0},
        {128'hd0bfd0b8d188d0b820d0b220d0bbd181, 216'h0},
        {248'hd183d0b4d0b0d0bbd191d0bdd0bdd0b0d18f20d180d0b0d0b1d0bed182d0b0, 96'h0},
        {176'hd0b4d0bed185d0bed0b420d0b220d0b4d0b5d0bdd18c, 168'h0},
        {152'hd0b2d18b20d0bfd0bbd18bd0b2d0b5d182d0b5, 192'h0},
        344'hd0bad0bed0bdd181d183d0bbd18cd182d0b0d186d0b8d18f20d0b1d0b5d181d0bfd0bbd0b0d182d0bdd0be
    };

    // One shift-and step of one phrase for one folded byte.
    function automatic progress_t match_step(input progress_t prog, input logic [7:0] b,
                                             input int p);
        progress_t nxt;
        logic      prev;
        nxt = '0;
        for (int j = 0; j < PHRASE_MAX_BYTES; j++) begin
            prev = (j == 0) ? 1'b1 : prog[(j == 0) ? 0 : j - 1];
            if (j < PHRASE_LEN[p] && prev
                && PHRASE_TEXT[p][(PHRASE_MAX_BYTES-1-j)*8 +: 8] == b)
            begin
                nxt[j] = 1'b1;
            end
        end
        return nxt;
    endfunction

endpackage

>>> hw/rtl/cfkm_match_bank.sv
module cfkm_match_bank (
    input  logic            clk,
    input  logic            rst_n,
    input  cfkm_pkg::feed_t feed,
    output cfkm_pkg::seen_t seen_next
);
    import cfkm_pkg::*;

    progress_t progress_reg  [PHRASE_COUNT];
    progress_t progress_next [PHRASE_COUNT];
    seen_t     seen_reg;
    seen_t     seen_reg_next;
    seen_t     hit;

    for (genvar p = 0; p < PHRASE_COUNT; p++) begin : g_phrase
        localparam int LAST_BIT = PHRASE_LEN[p] - 1;
        progress_t mid;
        progress_t fin;

        always_comb
        begin
            mid = feed.en_first ? match_step(progress_reg[p], feed.first_byte, p)
                                : progress_reg[p];
            fin = feed.en_second ? match_step(mid, feed.second_byte, p) : mid;
            hit[p] = (feed.en_first && mid[LAST_BIT]) || (feed.en_second && fin[LAST_BIT]);
            progress_next[p] = feed.clear ? '0 : fin;
        end
    end

    assign seen_next     = seen_reg | hit;
    assign seen_reg_next = feed.clear ? '0 : seen_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            for (int p = 0; p < PHRASE_COUNT; p++)
            begin
                progress_reg[p] <= '0;
            end
        end
        else
        begin
            seen_reg <= seen_reg_next;
            for (int p = 0; p < PHRASE_COUNT; p++)
            begin
                progress_reg[p] <= progress_next[p];
            end
        end
    end

endmodule

>>> hw/rtl/case_folding_keyword_matcher_unit.sv
// Channel  | Signals                              | Carries
// text     | text_valid, text_ready, text_byte,   | one raw UTF-8 byte per request
//          | last_byte                            |
// result   | result_valid, result_ready, found,   | one request per message, after
//          | phrase_index                         | its final byte
//
// One byte per cycle while no final byte waits behind an untaken result; a result is registered
// in the result register once its final byte has left the input register. The matcher bank
// advances all phrases by up to two folded bytes per byte; this unit does the folding.
// Reset clears the held lead byte, all matcher progress and the seen mask.
// The input register stalls only when a final byte waits behind an untaken result.
module case_folding_keyword_matcher_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                text_valid,
    output logic                                text_ready,
    input  logic [7:0]                          text_byte,
    input  logic                                last_byte,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic                                found,
    output logic [cfkm_pkg::PHRASE_INDEX_W-1:0] phrase_index
);
    import cfkm_pkg::*;

    logic                      in_valid_reg, in_valid_next;
    logic [7:0]                byte_reg, byte_next;
    logic                      last_reg, last_next;
    logic                      lead_reg, lead_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      found_reg, found_next;
    logic [PHRASE_INDEX_W-1:0] index_reg, index_next;

    logic                      proc_ok;
    logic                      process;
    feed_t                     feed;
    seen_t                     seen_next;
    logic [PHRASE_INDEX_W-1:0] first_hit;

    // A final byte may only go through when the result register can take it.
    assign proc_ok    = !last_reg || !out_valid_reg || result_ready;
    assign process    = in_valid_reg && proc_ok;
    assign text_ready = !in_valid_reg || proc_ok;

    always_comb
    begin
        feed             = '0;
        feed.first_byte  = byte_reg;
        feed.second_byte = byte_reg;
        lead_next        = lead_reg;
        if (process)
        begin
            feed.clear = last_reg;
            lead_next  = 1'b0;
            if (lead_reg)
            begin
                feed.en_first  = 1'b1;
                feed.en_second = 1'b1;
                feed.first_byte = LEAD_D0;
                if (byte_reg >= CYR_CAP_LO && byte_reg <= CYR_CAP_MID)
                begin
                    feed.second_byte = byte_reg + CASE_DELTA;
                end
                else if (byte_reg > CYR_CAP_MID && byte_reg <= CYR_CAP_HI)
                begin
                    feed.first_byte  = LEAD_D1;
                    feed.second_byte = byte_reg - CASE_DELTA;
                end
                else if (byte_reg == CYR_IO_CAP)
                begin
                    feed.first_byte  = LEAD_D1;
                    feed.second_byte = CYR_IO_SMALL;
                end
            end
            else if (byte_reg >= ASCII_UPPER_LO && byte_reg <= ASCII_UPPER_HI)
            begin
                feed.en_first   = 1'b1;
                feed.first_byte = byte_reg + CASE_DELTA;
            end
            else if (byte_reg == LEAD_D0 && !last_reg)
            begin
                lead_next = 1'b1;
            end
            else
            begin
                feed.en_first = 1'b1;
            end
        end
    end

    cfkm_match_bank u_bank (
        .clk       (clk),
        .rst_n     (rst_n),
        .feed      (feed),
        .seen_next (seen_next)
    );

    always_comb
    begin
        first_hit = '0;
        for (int p = PHRASE_COUNT - 1; p >= 0; p--)
        begin
            if (seen_next[p])
            begin
                first_hit = PHRASE_INDEX_W'(p);
            end
        end
    end

    always_comb
    begin
        in_valid_next  = text_ready ? text_valid : in_valid_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        if (text_valid && text_ready)
        begin
            byte_next = text_byte;
            last_next = last_byte;
        end

        out_valid_next = out_valid_reg && !result_ready;
        found_next     = found_reg;
        index_next     = index_reg;
        if (process && last_reg)
        begin
            out_valid_next = 1'b1;
            found_next     = |seen_next;
            index_next     = first_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            lead_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            lead_reg      <= lead_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        found_reg <= found_next;
        index_reg <= index_next;
    end

    assign result_valid = out_valid_reg;
    assign found        = found_reg;
    assign phrase_index = index_reg;

endmodule

>>> tb/case_folding_keyword_matcher_unit_test.sv
`timescale 1ns / 1ps

module case_folding_keyword_matcher_unit_test;

    import cfkm_pkg::*;

    localparam int WORDS       = 11;
    localparam int WORD_BYTES  = 43;
    localparam int HOLD_CYCLES = 300;

    localparam int WORD_LEN [WORDS] = '{38, 29, 21, 29, 26, 22, 16, 31, 22, 19, 43};

    // Lower-case phrases, first byte in the top byte, zero padded below.
    localparam logic [WORD_BYTES*8-1:0] WORD_ROM [WORDS] = '{
        {152'hd0b7d0b0d180d0b0d0b1d0bed182d0b0d0b920,
         152'hd0b220d182d0b5d0bbd0b5d0b3d180d0b0d0bc, 40'h0},
        {232'hd0bfd0b0d181d181d0b8d0b2d0bdd18bd0b920d0b4d0bed185d0bed0b4, 112'h0},
        {168'hd0b2d0bbd0bed0b6d0b5d0bdd0b8d0b520d0bed182, 176'h0},
        {232'hd0b3d0b0d180d0b0d0bdd182d0b8d18f20d0b4d0bed185d0bed0b4d0b0, 112'h0},
        {208'hd0bdd183d0b6d0bdd18b20d0bbd18ed0b4d0b820d0b4d0bbd18f, 136'h0},
        {176'hd181d181d18bd0bbd0bad0b020d0b220d0b1d0b8d0be, 168'h0},
        {128'hd0bfd0b8d188d0b820d0b220d0bbd181, 216'h0},
        {248'hd183d0b4d0b0d0bbd191d0bdd0bdd0b0d18f20d180d0b0d0b1d0bed182d0b0, 96'h0},
        {176'hd0b4d0bed185d0bed0b420d0b220d0b4d0b5d0bdd18c, 168'h0},
        {152'hd0b2d18b20d0bfd0bbd18bd0b2d0b5d182d0b5, 192'h0},
        {176'hd0bad0bed0bdd181d183d0bbd18cd182d0b0d186d0b8,
         168'hd18f20d0b1d0b5d181d0bfd0bbd0b0d182d0bdd0be}
    };

    typedef enum {WORD_WHOLE, WORD_CUT, WORD_SPOILED} word_form_t;

    typedef struct packed {
        logic                      hit;
        logic [PHRASE_INDEX_W-1:0] first_word;
    } verdict_t;

    logic                      clk;
    logic                      rst_n;
    logic                      text_valid;
    logic                      text_ready;
    logic [7:0]                text_byte;
    logic                      last_byte;
    logic                      result_valid;
    logic                      result_ready;
    logic                      found;
    logic [PHRASE_INDEX_W-1:0] phrase_index;

    // matcher shadow state
    logic                  lead_held;
    logic [WORD_BYTES-1:0] word_prog [WORDS];
    logic [WORDS-1:0]      word_seen;
    verdict_t              verdicts_due [$];

    logic [7:0] msg_bytes [$];
    int         bytes_sent;
    int         mismatches;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         hold_req;

    case_folding_keyword_matcher_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_ready   (text_ready),
        .text_byte    (text_byte),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .found        (found),
        .phrase_index (phrase_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("case_folding_keyword_matcher_unit test failed");
        $finish;
    end

    function automatic logic [7:0] word_byte(int p, int j);
        return WORD_ROM[p][(WORD_BYTES-1-j)*8 +: 8];
    endfunction

    function void add_byte(logic [7:0] b);
        msg_bytes = {msg_bytes, b};
    endfunction

    function void clear_matcher();
        lead_held = 1'b0;
        word_seen = '0;
        for (int p = 0; p < WORDS; p++)
            word_prog[p] = '0;
    endfunction

    // One shift-and step of every phrase for one folded byte.
    function void advance_words(logic [7:0] b);
        logic [WORD_BYTES-1:0] shifted;
        logic [WORD_BYTES-1:0] nxt;
        for (int p = 0; p < WORDS; p++)
        begin
            shifted = {word_prog[p][WORD_BYTES-2:0], 1'b1};
            nxt = '0;
            for (int j = 0; j < WORD_LEN[p]; j++)
                if (shifted[j] && word_byte(p, j) == b)
                    nxt[j] = 1'b1;
            word_prog[p] = nxt;
            if (nxt[WORD_LEN[p]-1])
                word_seen[p] = 1'b1;
        end
    endfunction

    function void absorb_byte(logic [7:0] b, logic fin);
        verdict_t v;
        if (lead_held)
        begin
            lead_held = 1'b0;
            if (b >= CYR_CAP_LO && b <= CYR_CAP_HI)
            begin
                if (b <= CYR_CAP_MID)
                begin
                    advance_words(LEAD_D0);
                    advance_words(b + CASE_DELTA);
                end
                else
                begin
                    advance_words(LEAD_D1);
                    advance_words(b - CASE_DELTA);
                end
            end
            else if (b == CYR_IO_CAP)
            begin
                advance_words(LEAD_D1);
                advance_words(CYR_IO_SMALL);
            end
            else
            begin
                advance_words(LEAD_D0);
                advance_words(b);
            end
        end
        else if (b >= ASCII_UPPER_LO && b <= ASCII_UPPER_HI)
            advance_words(b + CASE_DELTA);
        else if (b == LEAD_D0 && !fin)
            lead_held = 1'b1;
        else
            advance_words(b);

        if (fin)
        begin
            v.hit = |word_seen;
            v.first_word = '0;
            for (int p = WORDS - 1; p >= 0; p--)
                if (word_seen[p])
                    v.first_word = PHRASE_INDEX_W'(p);
            verdicts_due = {verdicts_due, v};
            clear_matcher();
        end
    endfunction

    // Phrase p with random letter case; whole, cut short or with one byte replaced.
    function void put_word(int p, word_form_t form);
        int         cut;
        int         spoil;
        int         j;
        logic [7:0] b;
        logic [7:0] nb;
        cut = WORD_LEN[p];
        spoil = -1;
        if (form == WORD_CUT)
            cut = $urandom_range(1, WORD_LEN[p] - 1);
        else if (form == WORD_SPOILED)
            spoil = $urandom_range(0, WORD_LEN[p] - 1);
        j = 0;
        while (j < cut)
        begin
            b = word_byte(p, j);
            nb = (j + 1 < cut) ? word_byte(p, j + 1) : 8'h00;
            if (j == spoil)
            begin
                add_byte(8'($urandom_range(0, 255)));
                j++;
            end
            else if (j + 1 < cut && j + 1 != spoil && $urandom_range(0, 1) == 1
                     && ((b == LEAD_D0 && nb >= 8'hB0 && nb <= 8'hBF)
                         || (b == LEAD_D1 && nb >= 8'h80 && nb <= 8'h8F)
                         || (b == LEAD_D1 && nb == CYR_IO_SMALL)))
            begin
                add_byte(LEAD_D0);
                if (b == LEAD_D0)
                    add_byte(nb - CASE_DELTA);
                else if (nb == CYR_IO_SMALL)
                    add_byte(CYR_IO_CAP);
                else
                    add_byte(nb + CASE_DELTA);
                j += 2;
            end
            else
            begin
                add_byte(b);
                j++;
            end
        end
    endfunction

    function void put_filler(int n);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 5))
                0: add_byte(8'($urandom_range(0, 1) ? 8'h61 : 8'h41)
                            + 8'($urandom_range(0, 25)));
                1: add_byte(8'h20);
                2:
                begin
                    if ($urandom_range(0, 1))
                    begin
                        add_byte(LEAD_D0);
                        add_byte(8'($urandom_range(8'hB0, 8'hBF)));
                    end
                    else
                    begin
                        add_byte(LEAD_D1);
                        add_byte(8'($urandom_range(8'h80, 8'h91)));
                    end
                end
                3:
                begin
                    add_byte(LEAD_D0);
                    add_byte($urandom_range(0, 7) == 0 ? CYR_IO_CAP
                             : 8'($urandom_range(CYR_CAP_LO, CYR_CAP_HI)));
                end
                4: add_byte(8'($urandom_range(0, 255)));
                default:
                begin
                    add_byte(LEAD_D0);
                    add_byte(8'($urandom_range(0, 255)));
                end
            endcase
        end
    endfunction

    function void put_noise(int n);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 3))
                0: add_byte(LEAD_D0);
                1: add_byte(8'($urandom_range(8'h80, 8'hAF)));
                2: add_byte(8'($urandom_range(8'h40, 8'h5B)));
                default: add_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    function word_form_t pick_form();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return WORD_CUT;
        if (r == 1)
            return WORD_SPOILED;
        return WORD_WHOLE;
    endfunction

    function void build_message();
        if ($urandom_range(0, 9) < 7)
        begin
            put_filler($urandom_range(0, 6));
            put_word($urandom_range(0, WORDS - 1), pick_form());
            if ($urandom_range(0, 9) < 3)
            begin
                put_filler($urandom_range(0, 3));
                put_word($urandom_range(0, WORDS - 1), pick_form());
            end
            put_filler($urandom_range(0, 6));
        end
        else
            put_noise($urandom_range(1, 20));
    endfunction

    task automatic drive_byte(logic [7:0] b, logic fin);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            text_valid <= 1'b0;
            @(posedge clk);
        end
        text_valid <= 1'b1;
        text_byte <= b;
        last_byte <= fin;
        @(posedge clk);
        while (!text_ready)
            @(posedge clk);
        absorb_byte(b, fin);
        bytes_sent++;
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_bytes.size(); i++)
            drive_byte(msg_bytes[i], i == msg_bytes.size() - 1);
        msg_bytes.delete();
    endtask

    task automatic park_sender();
        text_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_all_verdicts();
        while (verdicts_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_field(string name, int want, int got);
        mismatches++;
        if (mismatches <= 10)
            $display("%s mismatch: expected %0d, got %0d", name, want, got);
    endtask

    // Result checker and receiver-side ready.
    initial
    begin
        int       hold_left;
        int       hold_ack;
        verdict_t want;
        hold_left = 0;
        hold_ack = 0;
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: found=%0b phrase_index=%0d",
                                 found, phrase_index);
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (found !== want.hit)
                        report_field("found", want.hit, found);
                    if (phrase_index !== want.first_word)
                        report_field("phrase_index", want.first_word, phrase_index);
                end
            end
            if (hold_req != hold_ack)
            begin
                hold_ack = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Extremes of the byte, case folding edges and lead byte corner cases.
    task automatic test_fold_edges();
        msg_bytes = {8'h00};
        send_message();
        msg_bytes = {8'hFF};
        send_message();
        msg_bytes = {ASCII_UPPER_LO, 8'h40, 8'h5B, ASCII_UPPER_HI};
        send_message();
        // lead byte as the final byte
        msg_bytes = {LEAD_D0};
        send_message();
        // a held lead consumes the next byte even if it is A-Z or another lead
        msg_bytes = {LEAD_D0, CYR_CAP_LO, LEAD_D0, CYR_CAP_MID, LEAD_D0, 8'hA0,
                     LEAD_D0, CYR_CAP_HI, LEAD_D0, CYR_IO_CAP, LEAD_D0, ASCII_UPPER_LO,
                     LEAD_D0, LEAD_D0, LEAD_D0};
        send_message();
        park_sender();
        wait_all_verdicts();
    endtask

    task automatic test_random_messages(int upto);
        send_idle_pct = 38;
        recv_idle_pct = 38;
        while (bytes_sent < upto)
        begin
            build_message();
            send_message();
        end
        park_sender();
    endtask

    task automatic test_back_to_back(int upto);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (bytes_sent < upto)
        begin
            build_message();
            send_message();
        end
        park_sender();
        wait_all_verdicts();
    endtask

    // Results held off while short messages keep coming; the input must stall.
    task automatic test_result_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 38;
        hold_req <= hold_req + 1;
        @(posedge clk);
        for (int i = 0; i < 10; i++)
        begin
            put_noise($urandom_range(1, 3));
            send_message();
        end
        park_sender();
        wait_all_verdicts();
    endtask

    // Sender goes quiet until every result is back, several times over.
    task automatic test_drain_pause();
        send_idle_pct = 38;
        recv_idle_pct = 38;
        for (int i = 0; i < 6; i++)
        begin
            build_message();
            send_message();
            park_sender();
            wait_all_verdicts();
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        text_valid <= 1'b0;
        text_byte <= 8'h00;
        last_byte <= 1'b0;
        bytes_sent = 0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 0;
        clear_matcher();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fold_edges();
        test_random_messages(1000);
        test_back_to_back(1430);
        test_result_backpressure();
        test_drain_pause();

        wait_all_verdicts();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("case_folding_keyword_matcher_unit test passed");
        else
            $display("case_folding_keyword_matcher_unit test failed");
        $finish;
    end

endmodule
